>>> hdl/alld_pkg.sv
package alld_pkg;

    localparam int DEPTH   = 32;
    localparam int ADDR_W  = $clog2(DEPTH);
    localparam int VALUE_W = 16;
    localparam int LINK_W  = 6;
    localparam int STEP_W  = $clog2(DEPTH + 1);
    localparam int KIND_W  = 3;
    localparam int TDATA_W = 32;

    localparam logic [LINK_W-1:0] END_MARK = LINK_W'(DEPTH);

    typedef enum logic [KIND_W-1:0] {
        KIND_WRITE   = 3'd0,
        KIND_HEAD    = 3'd1,
        KIND_DEL_VAL = 3'd2,
        KIND_DEL_IDX = 3'd3,
        KIND_READ    = 3'd4
    } t_kind;

    localparam logic STATUS_OK   = 1'b0;
    localparam logic STATUS_MISS = 1'b1;

    // per-node verdict of the match unit
    typedef struct packed {
        logic stop;  // end mark reached or walk too long
        logic hit;   // current node matches the key
    } t_walk_stat;

endpackage

>>> hdl/alld_ram.sv
module alld_ram #(
    parameter int WIDTH = 16,
    parameter int DEPTH = 32
) (
    input  logic                     i_clk,
    input  logic                     i_we,
    input  logic [$clog2(DEPTH)-1:0] i_waddr,
    input  logic [WIDTH-1:0]         i_wdata,
    input  logic [$clog2(DEPTH)-1:0] i_raddr,
    output logic [WIDTH-1:0]         o_rdata
);

    logic [WIDTH-1:0] r_mem [DEPTH];
    logic [WIDTH-1:0] r_rdata;

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
        r_rdata <= r_mem[i_raddr];
    end

    assign o_rdata = r_rdata;

endmodule

>>> hdl/alld_match.sv
module alld_match (
    input  logic                       i_by_value,
    input  logic [alld_pkg::VALUE_W-1:0] i_key_value,
    input  logic [alld_pkg::ADDR_W-1:0]  i_key_index,
    input  logic [alld_pkg::VALUE_W-1:0] i_cand_value,
    input  logic [alld_pkg::LINK_W-1:0]  i_cand_node,
    input  logic [alld_pkg::STEP_W-1:0]  i_step,
    output alld_pkg::t_walk_stat         o_stat
);
    import alld_pkg::*;

    logic w_stop;
    logic w_eq;

    // any node number of DEPTH or more is an end mark
    assign w_stop = (i_cand_node >= END_MARK) || (i_step >= STEP_W'(DEPTH));
    assign w_eq   = i_by_value ? (i_cand_value == i_key_value)
                               : (i_cand_node[ADDR_W-1:0] == i_key_index);

    assign o_stat.stop = w_stop;
    assign o_stat.hit  = !w_stop && w_eq;

endmodule

>>> hdl/array_linked_list_delete_unit.sv
// array-backed singly linked list with delete
//
// slave channel (i_s_*): one beat per request. tuser carries the kind (write
// entry, set head, delete by value, delete by index, read entry), tdata the
// index, value and link. master channel (o_m_*): exactly one result beat per
// request, tuser is the status (0 done / deleted, 1 not found), tdata holds the
// deleted node index and the read value and link.
//
// sequence: write entry and set head go from the idle state straight to the
// response step, read entry passes a memory read step (S_RDATA) first, and a
// delete walks the list node by node until a match, the end mark or DEPTH
// nodes without a match. the next request is taken only once the result has
// moved to the output register. the walk is set by the one read port of the
// node memories: each cycle reads one node and the next address comes
// straight from its link. o_s_tready is high only while the sequencer is idle.
//
// reset clears the head to the end mark (empty list) and the output valid flag.
// the node memories are not cleared and must be written before use. when the
// receiver stalls the finished beat waits in the output register; the block
// still takes the next request and holds its result until the slot frees.
module array_linked_list_delete_unit (
    input  logic                          i_clk,
    input  logic                          i_rst_n,
    // request channel
    input  logic                          i_s_tvalid,
    output logic                          o_s_tready,
    input  logic [alld_pkg::TDATA_W-1:0]  i_s_tdata,  // index[4:0], value[20:5], link[26:21]
    input  logic [alld_pkg::KIND_W-1:0]   i_s_tuser,  // kind[2:0]
    // result channel
    output logic                          o_m_tvalid,
    input  logic                          i_m_tready,
    output logic [alld_pkg::TDATA_W-1:0]  o_m_tdata,  // hit_index[4:0], read_value[20:5], read_link[26:21]
    output logic                          o_m_tuser   // status[0]
);
    import alld_pkg::*;

    typedef enum logic [1:0] {
        S_IDLE,
        S_RDATA,
        S_WALK,
        S_RESP
    } t_state;

    localparam int VAL_LO  = ADDR_W;
    localparam int LINK_LO = ADDR_W + VALUE_W;
    localparam int USED_W  = ADDR_W + VALUE_W + LINK_W;

    // request fields
    logic [ADDR_W-1:0]  w_in_index;
    logic [VALUE_W-1:0] w_in_value;
    logic [LINK_W-1:0]  w_in_link;
    t_kind              w_in_kind;
    logic               w_accept;

    assign w_in_index = i_s_tdata[ADDR_W-1:0];
    assign w_in_value = i_s_tdata[LINK_LO-1:VAL_LO];
    assign w_in_link  = i_s_tdata[USED_W-1:LINK_LO];
    assign w_in_kind  = t_kind'(i_s_tuser);
    assign w_accept   = i_s_tvalid && o_s_tready;

    // sequencer state
    t_state             r_state;
    logic [LINK_W-1:0]  r_head;
    logic [LINK_W-1:0]  r_cur;
    logic [ADDR_W-1:0]  r_prev;
    logic               r_have_prev;
    logic [STEP_W-1:0]  r_step;
    logic               r_by_value;
    logic [ADDR_W-1:0]  r_key_index;
    logic [VALUE_W-1:0] r_key_value;

    // pending result
    logic               r_res_status;
    logic [ADDR_W-1:0]  r_res_hit;
    logic [VALUE_W-1:0] r_res_value;
    logic [LINK_W-1:0]  r_res_link;

    // output register
    logic               r_out_valid;
    logic               r_out_status;
    logic [ADDR_W-1:0]  r_out_hit;
    logic [VALUE_W-1:0] r_out_value;
    logic [LINK_W-1:0]  r_out_link;

    // memory ports
    logic               w_val_we;
    logic               w_lnk_we;
    logic [ADDR_W-1:0]  w_lnk_waddr;
    logic [LINK_W-1:0]  w_lnk_wdata;
    logic [ADDR_W-1:0]  w_raddr;
    logic [VALUE_W-1:0] w_val_q;
    logic [LINK_W-1:0]  w_lnk_q;

    t_walk_stat         w_stat;
    logic               w_out_free;

    assign w_out_free = !r_out_valid || i_m_tready;
    assign o_s_tready = (r_state == S_IDLE);

    always_comb begin
        w_val_we    = 1'b0;
        w_lnk_we    = 1'b0;
        w_lnk_waddr = w_in_index;
        w_lnk_wdata = w_in_link;
        w_raddr     = r_head[ADDR_W-1:0];
        case (r_state)
            S_IDLE: begin
                if (w_accept && (w_in_kind == KIND_WRITE)) begin
                    w_val_we = 1'b1;
                    w_lnk_we = 1'b1;
                end
                if (w_in_kind == KIND_READ) begin
                    w_raddr = w_in_index;
                end
            end
            S_WALK: begin
                // follow the link of the node just read
                w_raddr = w_lnk_q[ADDR_W-1:0];
                if (w_stat.hit && r_have_prev) begin
                    // splice: predecessor takes the deleted node's link
                    w_lnk_we    = 1'b1;
                    w_lnk_waddr = r_prev;
                    w_lnk_wdata = w_lnk_q;
                end
            end
            default: begin
            end
        endcase
    end

    alld_ram #(
        .WIDTH (VALUE_W),
        .DEPTH (DEPTH)
    ) u_val_ram (
        .i_clk   (i_clk),
        .i_we    (w_val_we),
        .i_waddr (w_in_index),
        .i_wdata (w_in_value),
        .i_raddr (w_raddr),
        .o_rdata (w_val_q)
    );

    alld_ram #(
        .WIDTH (LINK_W),
        .DEPTH (DEPTH)
    ) u_lnk_ram (
        .i_clk   (i_clk),
        .i_we    (w_lnk_we),
        .i_waddr (w_lnk_waddr),
        .i_wdata (w_lnk_wdata),
        .i_raddr (w_raddr),
        .o_rdata (w_lnk_q)
    );

    alld_match u_match (
        .i_by_value   (r_by_value),
        .i_key_value  (r_key_value),
        .i_key_index  (r_key_index),
        .i_cand_value (w_val_q),
        .i_cand_node  (r_cur),
        .i_step       (r_step),
        .o_stat       (w_stat)
    );

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= S_IDLE;
            r_head      <= END_MARK;
            r_out_valid <= 1'b0;
        end else begin
            // the response step reloads the slot itself when it frees
            if (r_out_valid && i_m_tready && (r_state != S_RESP)) begin
                r_out_valid <= 1'b0;
            end
            case (r_state)
                S_IDLE: begin
                    if (w_accept) begin
                        r_res_status <= STATUS_OK;
                        r_res_hit    <= '0;
                        r_res_value  <= '0;
                        r_res_link   <= '0;
                        r_key_index  <= w_in_index;
                        r_key_value  <= w_in_value;
                        r_by_value   <= (w_in_kind == KIND_DEL_VAL);
                        r_cur        <= r_head;
                        r_have_prev  <= 1'b0;
                        r_step       <= '0;
                        case (w_in_kind)
                            KIND_HEAD: begin
                                r_head  <= w_in_link;
                                r_state <= S_RESP;
                            end
                            KIND_DEL_VAL, KIND_DEL_IDX: begin
                                r_state <= S_WALK;
                            end
                            KIND_READ: begin
                                r_state <= S_RDATA;
                            end
                            default: begin
                                // entry write goes through the memory ports,
                                // unknown kinds change nothing
                                r_state <= S_RESP;
                            end
                        endcase
                    end
                end
                S_RDATA: begin
                    r_res_value <= w_val_q;
                    r_res_link  <= w_lnk_q;
                    r_state     <= S_RESP;
                end
                S_WALK: begin
                    if (w_stat.stop) begin
                        r_res_status <= STATUS_MISS;
                        r_state      <= S_RESP;
                    end else if (w_stat.hit) begin
                        if (!r_have_prev) begin
                            // deleting the first node moves the head
                            r_head <= w_lnk_q;
                        end
                        r_res_hit <= r_cur[ADDR_W-1:0];
                        r_state   <= S_RESP;
                    end else begin
                        r_prev      <= r_cur[ADDR_W-1:0];
                        r_have_prev <= 1'b1;
                        r_cur       <= w_lnk_q;
                        r_step      <= r_step + 1'b1;
                    end
                end
                S_RESP: begin
                    if (w_out_free) begin
                        r_out_valid  <= 1'b1;
                        r_out_status <= r_res_status;
                        r_out_hit    <= r_res_hit;
                        r_out_value  <= r_res_value;
                        r_out_link   <= r_res_link;
                        r_state      <= S_IDLE;
                    end
                end
                default: begin
                    r_state <= S_IDLE;
                end
            endcase
        end
    end

    assign o_m_tvalid = r_out_valid;
    assign o_m_tuser  = r_out_status;
    assign o_m_tdata  = {{(TDATA_W - USED_W){1'b0}}, r_out_link, r_out_value, r_out_hit};

    // one request in work at a time
    a_busy_after_accept: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        w_accept |=> !o_s_tready)
        else $error("request accepted while a request is in work");

    // walk never visits more than DEPTH nodes
    a_step_bound: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == S_WALK) |-> (r_step <= STEP_W'(DEPTH)))
        else $error("list walk ran past its bound");

    // a result beat only comes out of the response step
    a_out_from_resp: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        $rose(o_m_tvalid) |-> ($past(r_state) == S_RESP))
        else $error("result beat raised outside the response step");

    // a miss never reports a deleted node
    a_miss_no_hit: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_m_tvalid && (o_m_tuser == STATUS_MISS)) |-> (o_m_tdata[ADDR_W-1:0] == '0))
        else $error("not-found result carries a node index");

    // a splice write always targets the node ahead of the match
    a_splice_prev: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        ((r_state == S_WALK) && w_lnk_we) |-> (r_have_prev && w_stat.hit))
        else $error("link write during walk without a match behind a predecessor");

endmodule
